// ===== sv/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types and fixed constants of the weighted centroid line position
// block: request and result payloads, sample range, position scale.
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int SAMPLE_W          = 10;
  localparam int POS_W             = 13;
  localparam int SAMPLE_MAX        = 1023;
  localparam int POS_SCALE         = 1000;
  localparam int POS_MAX           = 8191;
  localparam int NOISE_FLOOR_RESET = 5;
  localparam int QUEUE_DEPTH       = 2;

  // one sensor reading
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } swc_in_t;

  // one scan result
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } swc_out_t;

endpackage

// ===== sv/swc_front.sv =====
// ----------------------------------------------------------------------------
// swc_front
// Takes readings, gates them against the noise floor, forms the weighted
// product and accumulates both sums; pushes the totals of a scan on last.
// ----------------------------------------------------------------------------
module swc_front #(
  parameter int NUM_SENSORS = 8,
  parameter int SUM_W       = 25,
  parameter int TOT_W       = 13,
  parameter int LVL_W       = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  swc_pkg::swc_in_t      item,
  input  logic                  wr_en,
  input  logic [swc_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [LVL_W-1:0]      q_level,
  output logic                  push,
  output logic [SUM_W-1:0]      push_sum,
  output logic [TOT_W-1:0]      push_total
);
  import swc_pkg::*;

  localparam int IDX_W  = $clog2(NUM_SENSORS + 1);
  localparam int IDXK_W = $clog2(POS_SCALE * NUM_SENSORS + 1);
  localparam int PROD_W = SAMPLE_W + IDXK_W;

  logic [SAMPLE_W-1:0] noise_floor;
  logic [IDX_W-1:0]    idx;
  logic [IDXK_W-1:0]   idx_k;
  logic                s1_valid;
  logic                s1_last;
  logic [SUM_W-1:0]    s1_prod;
  logic [TOT_W-1:0]    s1_add;
  logic [SUM_W-1:0]    wsum;
  logic [TOT_W-1:0]    total;

  logic                accept;
  logic                pass;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    wsum_next;
  logic [TOT_W-1:0]    total_next;

  // hold off while the queue is full or a scan ending in stage 1 could find it full
  assign busy   = ({1'b0, q_level} + (LVL_W+1)'(s1_valid && s1_last))
                  >= (LVL_W+1)'(QUEUE_DEPTH);
  assign accept = start && !busy;

  // gate and weight the reading
  assign pass = (idx < IDX_W'(NUM_SENSORS)) && (item.sample > noise_floor);
  assign prod = PROD_W'(item.sample) * PROD_W'(idx_k);

  // stage 2 sums
  assign wsum_next  = wsum + s1_prod;
  assign total_next = total + s1_add;
  assign push       = s1_valid && s1_last;
  assign push_sum   = wsum_next;
  assign push_total = total_next;

  // noise floor register
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor <= SAMPLE_W'(NOISE_FLOOR_RESET);
    end else if (wr_en) begin
      noise_floor <= wr_data;
    end
  end

  // sensor index and scaled index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      idx_k <= '0;
    end else if (accept) begin
      if (item.last) begin
        idx   <= '0;
        idx_k <= '0;
      end else if (idx < IDX_W'(NUM_SENSORS)) begin
        idx   <= idx + IDX_W'(1);
        idx_k <= idx_k + IDXK_W'(POS_SCALE);
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept && item.last;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod <= pass ? SUM_W'(prod) : '0;
      s1_add  <= pass ? TOT_W'(item.sample) : '0;
    end
  end

  // accumulators, cleared at the end of each scan
  always_ff @(posedge clk) begin
    if (rst) begin
      wsum  <= '0;
      total <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        wsum  <= '0;
        total <= '0;
      end else begin
        wsum  <= wsum_next;
        total <= total_next;
      end
    end
  end

endmodule

// ===== sv/swc_queue.sv =====
// ----------------------------------------------------------------------------
// swc_queue
// Small register queue holding finished scan totals between the
// accumulator and the divider.
// ----------------------------------------------------------------------------
module swc_queue #(
  parameter int DATA_W = 38,
  parameter int DEPTH  = 2,
  parameter int LVL_W  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] head,
  output logic [LVL_W-1:0]  level
);
  import swc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign valid   = (level != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && (level != LVL_W'(DEPTH));
  assign do_pop  = pop && valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule

// ===== sv/swc_back.sv =====
// ----------------------------------------------------------------------------
// swc_back
// Takes scan totals from the queue, runs a restoring divide one quotient
// bit per cycle, saturates, and strobes out the position or the held one.
// ----------------------------------------------------------------------------
module swc_back #(
  parameter int SUM_W = 25,
  parameter int TOT_W = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [SUM_W-1:0]   q_sum,
  input  logic [TOT_W-1:0]   q_total,
  output logic               pop,
  output logic               done,
  output swc_pkg::swc_out_t  result
);
  import swc_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    IDLE,
    DIV,
    FINISH
  } state_t;

  state_t             state;
  logic [SUM_W-1:0]   quo;
  logic [TOT_W-1:0]   rem;
  logic [TOT_W-1:0]   dvsr;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   held;

  logic [TOT_W:0]     trial;
  logic               fits;
  logic [TOT_W:0]     diff;
  logic [POS_W-1:0]   sat;

  assign pop   = (state == IDLE) && q_valid;
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};
  assign sat   = (quo > SUM_W'(POS_MAX)) ? POS_W'(POS_MAX) : quo[POS_W-1:0];

  // divide sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      held  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (q_valid) begin
            if (q_total == '0) begin
              result.position <= held;
              result.found    <= 1'b0;
              done            <= 1'b1;
            end else begin
              quo   <= q_sum;
              rem   <= '0;
              dvsr  <= q_total;
              cnt   <= CNT_W'(SUM_W - 1);
              state <= DIV;
            end
          end
        end
        DIV: begin
          rem <= fits ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
          quo <= {quo[SUM_W-2:0], fits};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          held            <= sat;
          result.position <= sat;
          result.found    <= 1'b1;
          done            <= 1'b1;
          state           <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/sensor_array_weighted_centroid.sv =====
// ----------------------------------------------------------------------------
// sensor_array_weighted_centroid
// Weighted centroid of one row of sensor readings, in thousandths of a
// sensor pitch; holds the last position when no reading clears the floor.
// ----------------------------------------------------------------------------
//  channel   | signals               | flow
//  ----------+-----------------------+-------------------------------------
//  request   | start, busy, item     | taken when start high, busy low
//  result    | done, result          | one cycle per strobe, no back pressure
//  config    | wr_en, wr_data        | noise floor, written when wr_en high
//
// A reading is taken every cycle while busy is low. After the reading with
// last, the scan totals enter a two-entry queue; the divider takes a scan
// from it only when idle and runs a one-bit-per-cycle restoring divide, or
// skips the divide when nothing cleared the floor. busy rises only when
// the queue of finished scans could overflow. Reset is synchronous and sets
// the noise floor to 5, the held position to 0 and clears the sums.
// ----------------------------------------------------------------------------
module sensor_array_weighted_centroid #(
  parameter int NUM_SENSORS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  swc_pkg::swc_in_t             item,
  output logic                         done,
  output swc_pkg::swc_out_t            result,
  input  logic                         wr_en,
  input  logic [swc_pkg::SAMPLE_W-1:0] wr_data
);
  import swc_pkg::*;

  localparam int SUM_MAX = SAMPLE_MAX * POS_SCALE * NUM_SENSORS * (NUM_SENSORS - 1) / 2;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int TOT_W   = $clog2(SAMPLE_MAX * NUM_SENSORS + 1);
  localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W  = SUM_W + TOT_W;

  logic              push;
  logic [SUM_W-1:0]  push_sum;
  logic [TOT_W-1:0]  push_total;
  logic              pop;
  logic              q_valid;
  logic [DATA_W-1:0] q_head;
  logic [LVL_W-1:0]  q_level;

  // accumulating front
  swc_front #(
    .NUM_SENSORS (NUM_SENSORS),
    .SUM_W       (SUM_W),
    .TOT_W       (TOT_W),
    .LVL_W       (LVL_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .q_level    (q_level),
    .push       (push),
    .push_sum   (push_sum),
    .push_total (push_total)
  );

  // queue of finished scans
  swc_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH),
    .LVL_W  (LVL_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_total}),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head),
    .level     (q_level)
  );

  // dividing back end
  swc_back #(
    .SUM_W (SUM_W),
    .TOT_W (TOT_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_sum   (q_head[DATA_W-1:TOT_W]),
    .q_total (q_head[TOT_W-1:0]),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== sv/swc_checker.sv =====
// ----------------------------------------------------------------------------
// swc_checker
// Port-level checks of the centroid block: quiet after reset, no result
// without a finished scan, held position repeated when nothing is found.
// ----------------------------------------------------------------------------
module swc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input swc_pkg::swc_in_t  item,
  input logic              done,
  input swc_pkg::swc_out_t result
);
  import swc_pkg::*;

  logic [3:0]       pending;
  logic [POS_W-1:0] prev_pos;
  logic             scan_end;

  assign scan_end = start && !busy && item.last;

  // scans ended but not yet reported
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (scan_end && !done) begin
      pending <= pending + 4'd1;
    end else if (done && !scan_end) begin
      pending <= pending - 4'd1;
    end
  end

  // last position reported
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos <= '0;
    end else if (done) begin
      prev_pos <= result.position;
    end
  end

  // nothing pending right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy high right after reset");

  // every result belongs to a scan that ended earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> pending != 4'd0)
    else $error("result without a finished scan");

  // an empty scan repeats the previous position
  a_hold: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.position == prev_pos)
    else $error("held position changed on an empty scan");

endmodule

bind sensor_array_weighted_centroid swc_checker u_swc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the weighted centroid block against an in-bench predictor. Sensor
// readings are sent as scans (full, short and overlong) under several noise
// floors. Each position strobe is compared field by field with the queued
// expectation. The sender idles at random, and every noise floor change
// happens only after all pending scan results have arrived.
// ----------------------------------------------------------------------------
module testbench;
  import swc_pkg::*;

  localparam int NUM_SENSORS    = 8;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  swc_in_t  item;
  logic     done;
  swc_out_t result;
  logic     wr_en;
  logic [SAMPLE_W-1:0] wr_data;

  sensor_array_weighted_centroid #(.NUM_SENSORS(NUM_SENSORS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  // readings waiting to be sent and scan results waiting to arrive
  swc_in_t  pending_readings[$];
  swc_out_t expected_scans[$];

  // centroid predictor state
  logic [SAMPLE_W-1:0] floor_val;
  longint unsigned     wsum_acc;
  int unsigned         total_acc;
  int unsigned         sensor_idx;
  logic [POS_W-1:0]    held_pos;

  int  send_idle_pct;
  bit  req_taken;
  int  quiet_cycles;
  int  n_errors;
  int  n_requests;
  int  n_scans;
  int  n_found;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // apply one accepted reading; queue the scan result when it ends a scan
  task automatic track_reading(input swc_in_t r);
    swc_out_t        res;
    longint unsigned quo;
    if (sensor_idx < NUM_SENSORS) begin
      if (r.sample > floor_val) begin
        wsum_acc  += longint'(r.sample) * longint'(sensor_idx) * longint'(POS_SCALE);
        total_acc += r.sample;
      end
      sensor_idx++;
    end
    if (r.last) begin
      if (total_acc != 0) begin
        quo = wsum_acc / total_acc;
        if (quo > POS_MAX) quo = POS_MAX;
        held_pos = quo[POS_W-1:0];
      end
      res.position = held_pos;
      res.found    = (total_acc != 0);
      expected_scans.push_back(res);
      wsum_acc   = 0;
      total_acc  = 0;
      sensor_idx = 0;
    end
  endtask

  // driver: new request at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item  <= pending_readings.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: requests, result check and watchdog at the rising edge
  always @(posedge clk) begin
    swc_out_t want;
    req_taken = !rst && start && !busy;
    if (!rst) begin
      if (req_taken) begin
        n_requests++;
        track_reading(item);
      end
      if (done) begin
        if (expected_scans.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result position=%0d found=%0b",
                   $time, result.position, result.found);
        end else begin
          want = expected_scans.pop_front();
          n_scans++;
          if (want.found) n_found++;
          if (result.position !== want.position) begin
            n_errors++;
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, result.position);
          end
          if (result.found !== want.found) begin
            n_errors++;
            $display("%0t: found expected %0b actual %0b",
                     $time, want.found, result.found);
          end
        end
      end
      // watchdog on cycles with no traffic
      if (req_taken || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $time, expected_scans.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // wait until every reading is sent and every scan result has arrived
  task automatic wait_drained();
    while (pending_readings.size() != 0 || start || expected_scans.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // change the noise floor while the block is idle
  task automatic set_floor(input int value);
    wait_drained();
    @(negedge clk);
    wr_en     <= 1'b1;
    wr_data   <= value[SAMPLE_W-1:0];
    floor_val  = value[SAMPLE_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic push_reading(input int sample, input bit last);
    swc_in_t r;
    r.sample = sample[SAMPLE_W-1:0];
    r.last   = last;
    pending_readings.push_back(r);
  endtask

  // reading biased toward the floor boundary and the range ends
  function automatic int pick_sample(input bit dark);
    int f;
    f = floor_val;
    if (dark) return $urandom_range(f);
    case ($urandom_range(7))
      0:       return 0;
      1:       return SAMPLE_MAX;
      2:       return f;
      3:       return (f < SAMPLE_MAX) ? f + 1 : SAMPLE_MAX;
      default: return $urandom_range(SAMPLE_MAX);
    endcase
  endfunction

  // random scans: mostly full, some short, some running past the array
  task automatic queue_scans(input int n_items);
    int  queued;
    int  len;
    bit  dark;
    queued = 0;
    while (queued < n_items) begin
      case ($urandom_range(9))
        0:       len = NUM_SENSORS + $urandom_range(1, 3);
        1, 2:    len = $urandom_range(1, NUM_SENSORS - 1);
        default: len = NUM_SENSORS;
      endcase
      dark = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++)
        push_reading(pick_sample(dark), k == len - 1);
      queued += (len > NUM_SENSORS) ? NUM_SENSORS : len;
    end
  endtask

  // stimulus
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    wr_en         = 1'b0;
    wr_data       = '0;
    floor_val     = NOISE_FLOOR_RESET;
    wsum_acc      = 0;
    total_acc     = 0;
    sensor_idx    = 0;
    held_pos      = '0;
    send_idle_pct = 35;
    req_taken     = 0;
    quiet_cycles  = 0;
    n_errors      = 0;
    n_requests    = 0;
    n_scans       = 0;
    n_found       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one-reading scan at index 0 with full scale
    push_reading(SAMPLE_MAX, 1);
    // nothing above the floor right after reset
    push_reading(0, 1);
    // short scan: reading at the floor ignored, one above it counted
    push_reading(NOISE_FLOOR_RESET, 0);
    push_reading(NOISE_FLOOR_RESET + 1, 1);
    // full scan lit only at the far end
    for (int k = 0; k < NUM_SENSORS; k++)
      push_reading((k == NUM_SENSORS - 1) ? SAMPLE_MAX : 0, k == NUM_SENSORS - 1);
    // dark scan with bright readings past the array: position held
    for (int k = 0; k < NUM_SENSORS + 2; k++)
      push_reading((k < NUM_SENSORS) ? 0 : SAMPLE_MAX, k == NUM_SENSORS + 1);

    // random scans over several floors and sender idle rates
    set_floor(0);
    queue_scans(140);
    set_floor(SAMPLE_MAX);
    queue_scans(50);
    send_idle_pct = 74;
    set_floor($urandom_range(SAMPLE_MAX));
    queue_scans(150);
    set_floor(300);
    queue_scans(120);
    send_idle_pct = 0;
    set_floor(NOISE_FLOOR_RESET);
    queue_scans(170);

    wait_drained();
    $display("%0d readings sent, %0d scan results checked (%0d with an object found)",
             n_requests, n_scans, n_found);
    $display("floors 0, 5, 300, 1023 and one random; short, full and overlong scans");
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sensor_array_weighted_centroid.f =====
sv/swc_pkg.sv
sv/swc_front.sv
sv/swc_queue.sv
sv/swc_back.sv
sv/sensor_array_weighted_centroid.sv
sv/swc_checker.sv
tb/sv/testbench.sv
